[design/slqe_pkg.sv]
// slqe_pkg: shared types and constants of the sorted list query engine.
// Used by slqe_cell, slqe_out and sorted_list_query_engine; no dependencies.
`timescale 1ns / 1ps

package slqe_pkg;

  localparam int DATA_W        = 32;
  localparam int MAX_ITEMS_DEF = 32;
  localparam int CFG_IDX_W     = 2;
  localparam int MODE_W        = 3;
  localparam int KIND_W        = 2;
  localparam int USER_W        = 3;

  // Answer kinds
  localparam logic [KIND_W-1:0] KIND_VERDICT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_VALUE   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_NO_MAJ  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_EMPTY   = 2'd3;

  // Query modes
  localparam logic [MODE_W-1:0] MODE_PAIR_SUM = 3'd0;
  localparam logic [MODE_W-1:0] MODE_UNIQUE   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_MAJORITY = 3'd2;
  localparam logic [MODE_W-1:0] MODE_MEDIAN   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_RANGE    = 3'd4;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_QUERY_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_SUM = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_LOW  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_HIGH = 2'd3;

  localparam logic signed [DATA_W-1:0] TARGET_SUM_RST = 32'sd7777;
  localparam logic signed [DATA_W-1:0] RANGE_LOW_RST  = 32'sd100;
  localparam logic signed [DATA_W-1:0] RANGE_HIGH_RST = 32'sd1000;
  localparam logic signed [DATA_W-1:0] NO_MAJ_VALUE   = -32'sd1;

  // Broadcast to every cell of the chain
  typedef struct packed {
    logic                      ins;      // insert ins_val at its sorted place
    logic                      shl;      // shift toward cell 0
    logic signed [DATA_W-1:0]  ins_val;
    logic signed [DATA_W:0]    need;     // partner value the head is looking for
  } cell_ctrl_t;

  // Result events from the query sequencer to the output stage
  typedef struct packed {
    logic                      push;
    logic                      flush;    // mark the held result as the last one
    logic [KIND_W-1:0]         kind;
    logic signed [DATA_W-1:0]  value;
    logic                      ovf;
  } res_evt_t;

endpackage

[design/sorted_list_query_engine.sv]
// sorted_list_query_engine: top level with the insertion chain and query sequencer.
// Depends on slqe_pkg, slqe_cell and slqe_out.
`timescale 1ns / 1ps

// Values enter on the slave stream, one per cycle, and drop into place in a
// chain of MAX_ITEMS cells that keeps them in ascending order; a value that
// arrives when the chain is full is dropped and flagged. The item with tlast
// set closes the list: the input then stalls while the chain drains one entry
// per cycle past the query logic, unless the output stage holds it, and the
// query logic answers the mode in query_mode. Once the output stage has taken
// the answer, which waits while the master side holds tready low, the chain
// is empty and the next list may start. Configuration writes are taken in
// any cycle and must only be issued while no list is being answered.
module sorted_list_query_engine import slqe_pkg::*; #(
  parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [DATA_W-1:0]     s_axis_tdata,   // [31:0] sample_value
  input  logic                  s_axis_tlast,   // last_sample
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [DATA_W-1:0]     m_axis_tdata,   // [31:0] answer_value
  output logic [USER_W-1:0]     m_axis_tuser,   // [1:0] answer_kind, [2] overflowed
  output logic                  m_axis_tlast,   // last_answer
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [DATA_W-1:0]     cfg_data_i
);

  localparam int CW = $clog2(MAX_ITEMS + 1);
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_ITEMS);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DRAIN,
    ST_SETTLE,
    ST_FINAL,
    ST_FLUSH
  } state_e;

  // Configuration
  logic [MODE_W-1:0]        mode_q;
  logic signed [DATA_W-1:0] target_q, low_q, high_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_PAIR_SUM;
      target_q <= TARGET_SUM_RST;
      low_q    <= RANGE_LOW_RST;
      high_q   <= RANGE_HIGH_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_QUERY_MODE: mode_q   <= cfg_data_i[MODE_W-1:0];
        CFG_TARGET_SUM: target_q <= cfg_data_i;
        CFG_RANGE_LOW:  low_q    <= cfg_data_i;
        CFG_RANGE_HIGH: high_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Control state
  state_e                   state_q;
  logic [CW-1:0]            cnt_q, n_q, idx_q, run_q;
  logic                     ovf_q, ans_ovf_q;
  logic                     hit_q, dup_q, maj_q, emitted_q;
  logic signed [DATA_W-1:0] maj_val_q, prev_q;
  logic [MAX_ITEMS-1:0]     match_q;

  // Chain
  cell_ctrl_t               ctrl;
  logic signed [DATA_W-1:0] cell_val [MAX_ITEMS];
  logic [MAX_ITEMS-1:0]     cell_vld, cell_gt, match;

  genvar gi;
  generate
    for (gi = 0; gi < MAX_ITEMS; gi++) begin : g_cell
      logic signed [DATA_W-1:0] lval, rval;
      logic                     lvld, lgt, rvld;
      if (gi == 0) begin : g_first
        assign lval = '0;
        assign lvld = 1'b0;
        assign lgt  = 1'b0;
      end else begin : g_mid
        assign lval = cell_val[gi-1];
        assign lvld = cell_vld[gi-1];
        assign lgt  = cell_gt[gi-1];
      end
      if (gi == MAX_ITEMS - 1) begin : g_last
        assign rval = '0;
        assign rvld = 1'b0;
      end else begin : g_inner
        assign rval = cell_val[gi+1];
        assign rvld = cell_vld[gi+1];
      end
      slqe_cell u_cell (
        .clk_i       (clk_i),
        .rst_ni      (rst_ni),
        .ctrl_i      (ctrl),
        .left_val_i  (lval),
        .left_vld_i  (lvld),
        .left_gt_i   (lgt),
        .right_val_i (rval),
        .right_vld_i (rvld),
        .val_o       (cell_val[gi]),
        .vld_o       (cell_vld[gi]),
        .gt_o        (cell_gt[gi]),
        .match_o     (match[gi])
      );
    end
  endgenerate

  // Input side
  logic s_accept, room, trigger;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign room          = (cnt_q < MAX_CNT);
  assign trigger       = s_accept && s_axis_tlast;

  // Query datapath on the head of the chain
  logic signed [DATA_W-1:0] head;
  logic                     head_vld;
  logic [CW-1:0]            half, run_next;
  logic                     same_prev, in_rng, med_hit, drain_evt;
  logic                     advance, out_rdy;
  logic                     fin_push;
  logic [KIND_W-1:0]        fin_kind;
  logic signed [DATA_W-1:0] fin_val;
  res_evt_t                 evt;

  assign head     = cell_val[0];
  assign head_vld = cell_vld[0];
  assign half     = n_q >> 1;

  assign same_prev = (idx_q != '0) && (head == prev_q);
  assign run_next  = same_prev ? run_q + 1'b1 : CW'(1);
  assign in_rng    = (head >= low_q) && (head < high_q);
  assign med_hit   = (idx_q == half) || (!n_q[0] && (idx_q == half - 1'b1));

  always_comb begin
    case (mode_q)
      MODE_MEDIAN: drain_evt = med_hit;
      MODE_RANGE:  drain_evt = in_rng;
      default:     drain_evt = 1'b0;
    endcase
  end

  assign advance = (state_q == ST_DRAIN) && head_vld && (!drain_evt || out_rdy);

  always_comb begin
    fin_push = 1'b1;
    fin_kind = KIND_VERDICT;
    fin_val  = '0;
    case (mode_q)
      MODE_PAIR_SUM: fin_val = {{(DATA_W-1){1'b0}}, hit_q};
      MODE_UNIQUE:   fin_val = {{(DATA_W-1){1'b0}}, !dup_q};
      MODE_MAJORITY: begin
        fin_kind = maj_q ? KIND_VALUE : KIND_NO_MAJ;
        fin_val  = maj_q ? maj_val_q : NO_MAJ_VALUE;
      end
      MODE_MEDIAN, MODE_RANGE: begin
        fin_push = !emitted_q;
        fin_kind = KIND_EMPTY;
      end
      default: fin_push = 1'b0;
    endcase
  end

  always_comb begin
    ctrl.ins     = s_accept && room;
    ctrl.shl     = advance;
    ctrl.ins_val = s_axis_tdata;
    ctrl.need    = {target_q[DATA_W-1], target_q} - {head[DATA_W-1], head};

    evt.push  = ((state_q == ST_DRAIN) && head_vld && drain_evt) ||
                ((state_q == ST_FINAL) && fin_push);
    evt.flush = (state_q == ST_FLUSH);
    evt.kind  = (state_q == ST_DRAIN) ? KIND_VALUE : fin_kind;
    evt.value = (state_q == ST_DRAIN) ? head : fin_val;
    evt.ovf   = ans_ovf_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      n_q       <= '0;
      idx_q     <= '0;
      run_q     <= '0;
      ovf_q     <= 1'b0;
      ans_ovf_q <= 1'b0;
      hit_q     <= 1'b0;
      dup_q     <= 1'b0;
      maj_q     <= 1'b0;
      emitted_q <= 1'b0;
      maj_val_q <= '0;
      prev_q    <= '0;
      match_q   <= '0;
    end else begin
      match_q <= advance ? match : '0;
      // Clear the pair verdict when a new list closes
      hit_q   <= trigger ? 1'b0 : (hit_q | (|match_q));
      case (state_q)
        ST_IDLE: begin
          if (trigger) begin
            n_q       <= cnt_q + CW'(room);
            cnt_q     <= '0;
            ans_ovf_q <= ovf_q || !room;
            ovf_q     <= 1'b0;
            idx_q     <= '0;
            run_q     <= '0;
            dup_q     <= 1'b0;
            maj_q     <= 1'b0;
            emitted_q <= 1'b0;
            state_q   <= ST_DRAIN;
          end else if (s_accept) begin
            if (room) begin
              cnt_q <= cnt_q + 1'b1;
            end else begin
              ovf_q <= 1'b1;
            end
          end
        end
        ST_DRAIN: begin
          if (!head_vld) begin
            state_q <= ST_SETTLE;
          end else if (advance) begin
            idx_q  <= idx_q + 1'b1;
            prev_q <= head;
            run_q  <= run_next;
            if (same_prev) begin
              dup_q <= 1'b1;
            end
            if (run_next > half) begin
              maj_q     <= 1'b1;
              maj_val_q <= head;
            end
            if (drain_evt) begin
              emitted_q <= 1'b1;
            end
          end
        end
        ST_SETTLE: state_q <= ST_FINAL;
        ST_FINAL: begin
          if (!fin_push || out_rdy) begin
            state_q <= ST_FLUSH;
          end
        end
        ST_FLUSH: begin
          if (out_rdy) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  slqe_out u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .evt_i         (evt),
    .rdy_o         (out_rdy),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // Checks
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= MAX_CNT)
    else $error("entry count above capacity");

  a_ovf_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE && ovf_q) |-> (cnt_q == MAX_CNT))
    else $error("overflow flagged while chain has room");

  a_chain_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> ($countones(cell_vld) == int'(cnt_q)))
    else $error("occupied cells differ from entry count");

  a_drain_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SETTLE) |-> (cell_vld == '0))
    else $error("chain not empty after drain");

endmodule

[design/slqe_cell.sv]
// slqe_cell: one cell of the sorted insertion chain.
// Depends on slqe_pkg for the control struct and data width.
`timescale 1ns / 1ps

module slqe_cell import slqe_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  cell_ctrl_t               ctrl_i,
  input  logic signed [DATA_W-1:0] left_val_i,
  input  logic                     left_vld_i,
  input  logic                     left_gt_i,
  input  logic signed [DATA_W-1:0] right_val_i,
  input  logic                     right_vld_i,
  output logic signed [DATA_W-1:0] val_o,
  output logic                     vld_o,
  output logic                     gt_o,
  output logic                     match_o
);

  logic signed [DATA_W-1:0] val_q, val_d;
  logic                     vld_q, vld_d;

  // An empty cell counts as larger than any value.
  assign gt_o    = !vld_q || (val_q > ctrl_i.ins_val);
  assign match_o = vld_q && ({val_q[DATA_W-1], val_q} == ctrl_i.need);
  assign val_o   = val_q;
  assign vld_o   = vld_q;

  always_comb begin
    val_d = val_q;
    vld_d = vld_q;
    if (ctrl_i.ins && gt_o) begin
      if (left_gt_i) begin
        val_d = left_val_i;
        vld_d = left_vld_i;
      end else begin
        val_d = ctrl_i.ins_val;
        vld_d = 1'b1;
      end
    end else if (ctrl_i.shl) begin
      val_d = right_val_i;
      vld_d = right_vld_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

endmodule

[design/slqe_out.sv]
// slqe_out: result holding slot and output register of the answer stream.
// Depends on slqe_pkg; holds one result back so the last one can be marked.
`timescale 1ns / 1ps

module slqe_out import slqe_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  res_evt_t                 evt_i,
  output logic                     rdy_o,
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  output logic [DATA_W-1:0]        m_axis_tdata,   // [31:0] answer_value
  output logic [USER_W-1:0]        m_axis_tuser,   // [1:0] answer_kind, [2] overflowed
  output logic                     m_axis_tlast    // last_answer
);

  logic                     pend_vld_q;
  logic [KIND_W-1:0]        pend_kind_q;
  logic signed [DATA_W-1:0] pend_val_q;
  logic                     pend_ovf_q;

  logic                     out_vld_q;
  logic [KIND_W-1:0]        out_kind_q;
  logic signed [DATA_W-1:0] out_val_q;
  logic                     out_ovf_q;
  logic                     out_last_q;

  logic                     can_load;
  logic                     load_out;

  assign can_load = !out_vld_q || m_axis_tready;
  assign rdy_o    = !pend_vld_q || can_load;
  assign load_out = rdy_o && pend_vld_q && (evt_i.push || evt_i.flush);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      if (load_out) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
      if (rdy_o && evt_i.push) begin
        pend_vld_q <= 1'b1;
      end else if (rdy_o && evt_i.flush) begin
        pend_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_kind_q <= pend_kind_q;
      out_val_q  <= pend_val_q;
      out_ovf_q  <= pend_ovf_q;
      out_last_q <= evt_i.flush;
    end
    if (rdy_o && evt_i.push) begin
      pend_kind_q <= evt_i.kind;
      pend_val_q  <= evt_i.value;
      pend_ovf_q  <= evt_i.ovf;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_val_q;
  assign m_axis_tuser  = {out_ovf_q, out_kind_q};
  assign m_axis_tlast  = out_last_q;

endmodule
